// ===== sv/ratan_pkg.sv =====
// ----------------------------------------------------------------------------
// Rotation arctangent package
// Shared widths, payload types, control structs and the constant angle and
// tangent tables of the vectoring rotation unit.
// ----------------------------------------------------------------------------
package ratan_pkg;

   localparam int ITERATIONS = 32;
   localparam int ROM_DEPTH  = 32;
   localparam int ROM_AW     = $clog2(ROM_DEPTH);
   localparam int ROM_W      = 32;
   localparam int ROM_FRAC   = 31;
   localparam int MUL_W      = 32;
   localparam int SAMPLE_W   = 32;
   localparam int MAG_W      = SAMPLE_W + 1;
   localparam int Y_SHIFT    = 16;
   localparam int XY_W       = 50;
   localparam int Z_W        = 33;
   localparam int ANG_W      = 32;
   localparam int ANG_MAG_W  = ANG_W - 1;
   localparam int CNT_W      = ($clog2(ITERATIONS) > ROM_AW) ? $clog2(ITERATIONS) : ROM_AW;

   localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 32'sd1686629713;
   localparam logic signed [XY_W-1:0] X_INIT = XY_W'(64'h0000_0001_0000_0000);

   typedef logic [ROM_DEPTH-1:0][ROM_W-1:0] rom_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } req_type;

   typedef struct packed {
      logic signed [ANG_W-1:0] angle;
      logic                    last_out;
   } rsp_type;

   typedef struct packed {
      logic             start;
      logic [MAG_W-1:0] mag;
   } core_ctl_type;

   typedef struct packed {
      logic                  done;
      logic signed [Z_W-1:0] z;
   } core_sts_type;

   function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[125:62];
   endfunction

   function automatic logic [63:0] div_small(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[62:0], num[i]};
         if (r >= den) begin
            r    = r - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   function automatic logic [ROM_W-1:0] tan_q31(input logic [63:0] ang);
      logic [63:0] a2;
      logic [63:0] st;
      logic [63:0] sn;
      logic [63:0] ct;
      logic [63:0] cs;
      logic [63:0] q;
      logic [63:0] r;
      a2 = mul_q62(ang, ang);
      st = ang;
      sn = ang;
      ct = 64'd1 << 62;
      cs = 64'd1 << 62;
      for (int n = 1; n <= 14; n++) begin
         st = div_small(mul_q62(st, a2), 64'((2 * n) * (2 * n + 1)));
         ct = div_small(mul_q62(ct, a2), 64'((2 * n - 1) * (2 * n)));
         if ((n % 2) == 1) begin
            sn = sn - st;
            cs = cs - ct;
         end else begin
            sn = sn + st;
            cs = cs + ct;
         end
      end
      q = '0;
      r = sn;
      if (r >= cs) begin
         q = 64'd1;
         r = r - cs;
      end
      for (int n = 0; n < 32; n++) begin
         r = r << 1;
         q = q << 1;
         if (r >= cs) begin
            r = r - cs;
            q = q | 64'd1;
         end
      end
      q = (q + 64'd1) >> 1;
      return q[ROM_W-1:0];
   endfunction

   function automatic rom_type build_tan_rom();
      rom_type t;
      t = '0;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         t[k] = tan_q31(PI_Q60 >> k);
      end
      return t;
   endfunction

   function automatic rom_type build_ang_rom();
      rom_type t;
      logic [63:0] v;
      t = '0;
      for (int k = 0; k < ROM_DEPTH; k++) begin
         v    = (PI_Q60 + (64'd1 << (31 + k))) >> (32 + k);
         t[k] = v[ROM_W-1:0];
      end
      return t;
   endfunction

   localparam rom_type TAN_ROM = build_tan_rom();
   localparam rom_type ANG_ROM = build_ang_rom();

   function automatic logic [ROM_W-1:0] rom_tan(input logic [CNT_W-1:0] k);
      logic [ROM_W-1:0] v;
      v = '0;
      if ({1'b0, k} < (CNT_W + 1)'(ROM_DEPTH)) begin
         v = TAN_ROM[k[ROM_AW-1:0]];
      end
      return v;
   endfunction

   function automatic logic [ROM_W-1:0] rom_ang(input logic [CNT_W-1:0] k);
      logic [ROM_W-1:0] v;
      v = '0;
      if ({1'b0, k} < (CNT_W + 1)'(ROM_DEPTH)) begin
         v = ANG_ROM[k[ROM_AW-1:0]];
      end
      return v;
   endfunction

endpackage

// ===== sv/ratan_core.sv =====
// ----------------------------------------------------------------------------
// Rotation arctangent core
// Vectoring rotations through one shared 32x32 multiplier, four partial
// products and one closing add per rotation.
// ----------------------------------------------------------------------------
module ratan_core import ratan_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  core_ctl_type ctl,
   output core_sts_type sts
);

   localparam logic [2:0] PH_XLO  = 3'd0;
   localparam logic [2:0] PH_XHI  = 3'd1;
   localparam logic [2:0] PH_YLO  = 3'd2;
   localparam logic [2:0] PH_YHI  = 3'd3;
   localparam logic [2:0] PH_ADDX = 3'd4;

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [2:0]              phase_ff, phase_in;
   logic [CNT_W-1:0]        k_ff, k_in;
   logic signed [XY_W-1:0]  x_ff, x_in;
   logic signed [XY_W-1:0]  y_ff, y_in;
   logic signed [Z_W-1:0]   z_ff, z_in;
   logic [XY_W-1:0]         ymag_ff, ymag_in;
   logic                    yneg_ff, yneg_in;
   logic [2*MUL_W-1:0]      prod_ff, prod_in;

   logic [ROM_W-1:0]        tan_w;
   logic [ROM_W-1:0]        ang_w;
   logic [MUL_W-1:0]        mul_a;
   logic signed [XY_W-1:0]  lo_term;
   logic signed [XY_W-1:0]  hi_term;
   logic signed [XY_W-1:0]  y_term;
   logic signed [XY_W-1:0]  x_term;

   always_comb begin
      tan_w   = rom_tan(k_ff);
      ang_w   = rom_ang(k_ff);
      lo_term = XY_W'(prod_ff[2*MUL_W-1:ROM_FRAC]);
      hi_term = XY_W'({prod_ff, 1'b0});
      y_term  = (phase_ff == PH_XHI) ? lo_term : hi_term;
      x_term  = (phase_ff == PH_YHI) ? lo_term : hi_term;

      case (phase_ff)
         PH_XLO:  mul_a = x_ff[MUL_W-1:0];
         PH_XHI:  mul_a = MUL_W'(x_ff[XY_W-1:MUL_W]);
         PH_YLO:  mul_a = ymag_ff[MUL_W-1:0];
         PH_YHI:  mul_a = MUL_W'(ymag_ff[XY_W-1:MUL_W]);
         default: mul_a = '0;
      endcase
      prod_in = {{MUL_W{1'b0}}, mul_a} * {{(2*MUL_W-ROM_W){1'b0}}, tan_w};

      run_in   = run_ff;
      done_in  = 1'b0;
      phase_in = phase_ff;
      k_in     = k_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      ymag_in  = ymag_ff;
      yneg_in  = yneg_ff;

      if (ctl.start) begin
         run_in   = 1'b1;
         phase_in = PH_XLO;
         k_in     = '0;
         x_in     = X_INIT;
         y_in     = XY_W'({ctl.mag, {Y_SHIFT{1'b0}}});
         z_in     = '0;
      end else if (run_ff) begin
         case (phase_ff)
            PH_XLO: begin
               yneg_in  = y_ff[XY_W-1];
               ymag_in  = y_ff[XY_W-1] ? XY_W'(-y_ff) : XY_W'(y_ff);
               phase_in = PH_XHI;
            end
            PH_XHI, PH_YLO: begin
               y_in     = yneg_ff ? (y_ff + y_term) : (y_ff - y_term);
               phase_in = phase_ff + 3'd1;
            end
            PH_YHI: begin
               x_in     = x_ff + x_term;
               phase_in = PH_ADDX;
            end
            PH_ADDX: begin
               x_in     = x_ff + x_term;
               z_in     = yneg_ff ? (z_ff - Z_W'(ang_w)) : (z_ff + Z_W'(ang_w));
               phase_in = PH_XLO;
               if (k_ff == CNT_W'(ITERATIONS - 1)) begin
                  run_in  = 1'b0;
                  done_in = 1'b1;
               end else begin
                  k_in = k_ff + CNT_W'(1);
               end
            end
            default: begin
               phase_in = PH_XLO;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff   <= 1'b0;
         done_ff  <= 1'b0;
         phase_ff <= PH_XLO;
         k_ff     <= '0;
      end else begin
         run_ff   <= run_in;
         done_ff  <= done_in;
         phase_ff <= phase_in;
         k_ff     <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      ymag_ff <= ymag_in;
      yneg_ff <= yneg_in;
      prod_ff <= prod_in;
   end

   assign sts.done = done_ff;
   assign sts.z    = z_ff;

endmodule

// ===== sv/rotation_arctangent.sv =====
// ----------------------------------------------------------------------------
// Rotation arctangent
// Arctangent of one signed Q16.16 sample per transfer, returned as signed
// Q2.30 radians, by vectoring rotations in a shared multiply unit.
//
//   Channel   Direction  Payload   Handshake
//   req_      in         req_type  req_valid / req_stall
//   rsp_      out        rsp_type  rsp_valid / rsp_stall
//
// Each rotation runs the multiply phases XLO, XHI, YLO and YHI on the single
// 32x32 multiplier and closes with the add phase ADDX; the angle is then
// folded into range in the busy state and loaded in the finish state.
// The next transfer is taken once the result is loaded and the block is idle.
// Reset is synchronous; the tables are constants and need no fill.
// A stalled result holds in the output register and blocks only the final step.
// ----------------------------------------------------------------------------
module rotation_arctangent import ratan_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_BUSY   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic                 neg_ff, neg_in;
   logic                 last_ff, last_in;
   logic [ANG_MAG_W-1:0] zmag_ff, zmag_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;

   logic                 accept;
   logic                 out_free;
   logic signed [Z_W-1:0] zabs;
   logic signed [ANG_W-1:0] ang_pos;
   core_ctl_type         core_ctl;
   core_sts_type         core_sts;

   ratan_core u_core (
      .clock (clock),
      .reset (reset),
      .ctl   (core_ctl),
      .sts   (core_sts)
   );

   always_comb begin
      req_stall      = (state_ff != ST_IDLE);
      accept         = req_valid && !req_stall;
      out_free       = !rsp_valid_ff || !rsp_stall;

      core_ctl.start = accept;
      core_ctl.mag   = req_data.sample[SAMPLE_W-1]
                     ? ({1'b0, ~req_data.sample} + MAG_W'(1))
                     : {1'b0, req_data.sample};

      zabs    = core_sts.z[Z_W-1] ? -core_sts.z : core_sts.z;
      ang_pos = {1'b0, zmag_ff};

      state_in     = state_ff;
      neg_in       = neg_ff;
      last_in      = last_ff;
      zmag_in      = zmag_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in   = req_data.sample[SAMPLE_W-1];
               last_in  = req_data.last;
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (core_sts.done) begin
               if (zabs > Z_W'(HALF_PI_Q30)) begin
                  zmag_in = HALF_PI_Q30[ANG_MAG_W-1:0];
               end else begin
                  zmag_in = zabs[ANG_MAG_W-1:0];
               end
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.angle    = neg_ff ? -ang_pos : ang_pos;
               rsp_data_in.last_out = last_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      last_ff     <= last_in;
      zmag_ff     <= zmag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/ratan_checker.sv =====
// ----------------------------------------------------------------------------
// Rotation arctangent checker
// Port-level properties of the rotation arctangent, bound to the top level.
// ----------------------------------------------------------------------------
module ratan_checker import ratan_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // A stalled result stays valid and unchanged.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // Only one item is worked on at a time.
   a_busy_after_transfer: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again while busy");

   // A new result appears only at the end of the work on an item.
   a_result_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without work in progress");

   // The angle stays within a quarter turn either way.
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.angle <= HALF_PI_Q30) && (rsp_data.angle >= -HALF_PI_Q30))
      else $error("angle outside range");

endmodule

bind rotation_arctangent ratan_checker u_ratan_checker (.*);

// ===== sim/rotation_arctangent_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation arctangent testbench
// Drives signed Q16.16 samples into the block and checks each returned Q2.30
// angle and its last flag against a bit-exact vectoring rotation model kept
// here. Both channels idle in random bursts, except near the end of the run.
// ----------------------------------------------------------------------------
module rotation_arctangent_test;
   import ratan_pkg::*;

   localparam int CLOCK_PERIOD   = 10;
   localparam int RANDOM_ITEMS   = 1500;
   localparam int CALM_ITEMS     = 100;
   localparam int SETTLE_CYCLES  = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TABLE_SIZE     = 32;
   localparam logic [63:0] PI_SCALED = 64'h3243F6A8885A308D;
   localparam logic signed [63:0] ANGLE_LIMIT = 64'sd1686629713;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   logic [31:0] tan_table [TABLE_SIZE];
   logic [31:0] step_table [TABLE_SIZE];

   req_type stimulus_queue [$];
   rsp_type pending_angles [$];

   int errors      = 0;
   int idle_cycles = 0;
   int req_gap     = 0;
   int rsp_hold    = 0;
   bit req_taken   = 1'b0;
   bit stall_mode  = 1'b1;

   rotation_arctangent i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   function automatic logic [63:0] q62_product(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
   endfunction

   function automatic logic [31:0] tangent_of(input logic [63:0] angle);
      logic [63:0] sq;
      logic [63:0] sin_term;
      logic [63:0] sin_sum;
      logic [63:0] cos_term;
      logic [63:0] cos_sum;
      logic [63:0] quot;
      logic [63:0] rem;
      sq       = q62_product(angle, angle);
      sin_term = angle;
      sin_sum  = angle;
      cos_term = 64'd1 << 62;
      cos_sum  = 64'd1 << 62;
      for (int n = 1; n <= 14; n++) begin
         sin_term = q62_product(sin_term, sq) / 64'((2 * n) * (2 * n + 1));
         cos_term = q62_product(cos_term, sq) / 64'((2 * n - 1) * (2 * n));
         if ((n % 2) == 1) begin
            sin_sum = sin_sum - sin_term;
            cos_sum = cos_sum - cos_term;
         end else begin
            sin_sum = sin_sum + sin_term;
            cos_sum = cos_sum + cos_term;
         end
      end
      quot = '0;
      rem  = sin_sum;
      if (rem >= cos_sum) begin
         quot = 64'd1;
         rem  = rem - cos_sum;
      end
      for (int n = 0; n < 32; n++) begin
         rem  = rem << 1;
         quot = quot << 1;
         if (rem >= cos_sum) begin
            rem  = rem - cos_sum;
            quot = quot | 64'd1;
         end
      end
      quot = (quot + 64'd1) >> 1;
      return quot[31:0];
   endfunction

   // Product with an unsigned Q1.31 tangent, truncated toward zero.
   function automatic logic signed [63:0] scaled_by(input logic signed [63:0] v,
                                                     input logic [31:0] t);
      logic [63:0]  m;
      logic [127:0] p;
      logic [63:0]  r;
      m = (v < 0) ? -v : v;
      p = (128'(m) * 128'(t)) >> 31;
      r = p[63:0];
      return (v < 0) ? -$signed(r) : $signed(r);
   endfunction

   function automatic rsp_type arctan_of(input req_type item);
      logic [32:0]        mag;
      logic signed [63:0] x;
      logic signed [63:0] y;
      logic signed [63:0] z;
      logic signed [63:0] dx;
      logic signed [63:0] dy;
      logic [31:0]        t;
      logic [31:0]        a;
      rsp_type            r;
      mag = item.sample[31] ? (33'h1_0000_0000 - {1'b0, item.sample}) : {1'b0, item.sample};
      x   = 64'sd1 <<< 32;
      y   = $signed(64'(mag) << 16);
      z   = '0;
      for (int k = 0; k < ITERATIONS; k++) begin
         t  = (k < TABLE_SIZE) ? tan_table[k] : 32'd0;
         a  = (k < TABLE_SIZE) ? step_table[k] : 32'd0;
         dy = scaled_by(y, t);
         dx = scaled_by(x, t);
         if (y >= 0) begin
            x = x + dy;
            y = y - dx;
            z = z + $signed({32'd0, a});
         end else begin
            x = x - dy;
            y = y + dx;
            z = z - $signed({32'd0, a});
         end
      end
      if (z < 0) begin
         z = -z;
      end
      if (z > ANGLE_LIMIT) begin
         z = ANGLE_LIMIT;
      end
      r.angle    = item.sample[31] ? -z[31:0] : z[31:0];
      r.last_out = item.last;
      return r;
   endfunction

   function automatic logic [31:0] random_sample();
      logic [31:0] v;
      case ($urandom_range(0, 3))
         0: v = $urandom;
         1: v = $urandom_range(0, 32'h0010_0000);
         2: v = $urandom >> $urandom_range(0, 31);
         default: v = 32'h7FFF_FFFF - $urandom_range(0, 32'h0000_FFFF);
      endcase
      if ($urandom_range(0, 1) == 1) begin
         v = -v;
      end
      return v;
   endfunction

   task automatic add_sample(input logic [31:0] value, input logic flag);
      req_type item;
      item.sample = value;
      item.last   = flag;
      stimulus_queue.push_back(item);
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Inputs change on the falling edge only.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         rsp_stall <= 1'b0;
      end else begin
         if (!req_valid || req_taken) begin
            if (req_gap > 0) begin
               req_gap   = req_gap - 1;
               req_valid <= 1'b0;
            end else if (stimulus_queue.size() > 0) begin
               req_data  <= stimulus_queue.pop_front();
               req_valid <= 1'b1;
               if (stall_mode && stimulus_queue.size() >= CALM_ITEMS &&
                   $urandom_range(0, 5) == 0) begin
                  req_gap = $urandom_range(1, 17);
               end
               if ($urandom_range(0, 9) == 0) begin
                  stall_mode = !stall_mode;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
         if (rsp_hold > 0) begin
            rsp_hold  = rsp_hold - 1;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (stall_mode && stimulus_queue.size() >= CALM_ITEMS &&
                $urandom_range(0, 39) == 0) begin
               rsp_hold = $urandom_range(1, 17);
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      bit      rsp_taken;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (!reset) begin
         req_taken = req_valid && !req_stall;
         rsp_taken = rsp_valid && !rsp_stall;
         if (req_taken) begin
            pending_angles.push_back(arctan_of(req_data));
         end
         if (rsp_taken) begin
            if (pending_angles.size() == 0) begin
               errors++;
               $display("%0t: result with none pending: angle %h last_out %b",
                        $time, rsp_data.angle, rsp_data.last_out);
            end else begin
               want = pending_angles.pop_front();
               if (rsp_data.angle !== want.angle) begin
                  errors++;
                  $display("%0t: angle mismatch: expected %h actual %h",
                           $time, want.angle, rsp_data.angle);
               end
               if (rsp_data.last_out !== want.last_out) begin
                  errors++;
                  $display("%0t: last_out mismatch: expected %b actual %b",
                           $time, want.last_out, rsp_data.last_out);
               end
            end
         end
      end
      idle_cycles = (req_taken || rsp_taken) ? 0 : idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
      end
      $display("simulation failed");
      $finish;
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      rsp_stall = 1'b0;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         step_table[k] = 32'((PI_SCALED + (64'd1 << (31 + k))) >> (32 + k));
         tan_table[k]  = tangent_of(PI_SCALED >> k);
      end

      // Zero, unit and sign extremes, the most negative sample and saturation.
      add_sample(32'h0000_0000, 1'b0);
      add_sample(32'h0000_0000, 1'b1);
      add_sample(32'h0000_0001, 1'b0);
      add_sample(32'hFFFF_FFFF, 1'b1);
      add_sample(32'h0001_0000, 1'b0);
      add_sample(32'hFFFF_0000, 1'b0);
      add_sample(32'h7FFF_FFFF, 1'b1);
      add_sample(32'h8000_0000, 1'b0);
      add_sample(32'h8000_0001, 1'b1);
      add_sample(32'h7FFF_0000, 1'b0);
      add_sample(32'h0000_8000, 1'b0);
      add_sample(32'hFFFF_8000, 1'b1);
      add_sample(32'h0002_0000, 1'b0);
      add_sample(32'h0000_4000, 1'b0);
      add_sample(32'h0100_0000, 1'b1);
      add_sample(32'hFF00_0000, 1'b0);
      add_sample(32'h5555_5555, 1'b0);
      add_sample(32'hAAAA_AAAA, 1'b1);
      add_sample(32'h0000_0010, 1'b0);
      add_sample(32'hFFFF_FFF0, 1'b1);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         add_sample(random_sample(), 1'($urandom_range(0, 1)));
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stimulus_queue.size() > 0 || req_valid) begin
         @(posedge clock);
      end
      while (pending_angles.size() > 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (errors == 0 && pending_angles.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/ratan_pkg.sv
sv/ratan_core.sv
sv/rotation_arctangent.sv
sv/ratan_checker.sv
sim/rotation_arctangent_test.sv
